### hdl/okm_pkg.sv
// Shared types and constants for the online k-means update block.
package okm_pkg;

    localparam int DIST_W    = 39;
    localparam int TOTAL_W   = 63;
    localparam int CNT_W     = 32;
    localparam int ELEM_W    = 16;
    localparam int DIV_BITS  = 17;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] STATUS_TRAINED = 2'd0;
    localparam logic [1:0] STATUS_SEEDED  = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam logic [1:0] REG_CENTRES = 2'd0;
    localparam logic [1:0] REG_DIMS    = 2'd1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] element_value;
        logic               last_element;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  centre_index;
        logic [38:0] min_distance;
        logic [62:0] compactness;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        MODE_SEED,
        MODE_TRAIN,
        MODE_IGNORE
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_SCAN,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_UPD_RD,
        ST_UPD_DIV,
        ST_UPD_WAIT,
        ST_RESULT
    } t_state;

endpackage

### hdl/online_kmeans_update.sv
// Top level: online k-means centre update with APB configuration.
// Seed and ignored elements are taken in the idle state; a train element reads K centres
// one per cycle. A train descriptor's end adds a winner scan, a count update and, per element,
// a read, divide and write; the result waits in its stage until the output register takes it.
// Synchronous active-low reset clears control, seed slot, distance flags and the running total.
module online_kmeans_update #(
    parameter int MAX_CENTRES = 16,
    parameter int MAX_DIMS    = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  okm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output okm_pkg::t_out_item o_out_data
);
    import okm_pkg::*;

    logic [4:0] w_centres;
    logic [7:0] w_dims;
    logic       w_res_valid, w_res_ready;
    t_out_item  w_res_data;
    logic       r_out_valid;
    t_out_item  r_out_data;

    okm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_centres (w_centres),
        .o_dims    (w_dims)
    );

    okm_core #(
        .MAX_CENTRES (MAX_CENTRES),
        .MAX_DIMS    (MAX_DIMS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_centres   (w_centres),
        .i_dims      (w_dims),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_data  (w_res_data)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hdl/okm_cfg.sv
// APB register file holding the centre and dimension counts.
module okm_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [4:0]  o_centres,
    output logic [7:0]  o_dims
);
    import okm_pkg::*;

    logic [4:0] r_centres;
    logic [7:0] r_dims;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = {1'b0, paddr[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centres <= 5'd16;
            r_dims    <= 8'd128;
        end else if (w_wr) begin
            if (w_idx == REG_CENTRES) begin
                r_centres <= pwdata[4:0];
            end else if (w_idx == REG_DIMS) begin
                r_dims <= pwdata[7:0];
            end
        end
    end

    assign prdata    = (w_idx == REG_DIMS) ? {24'd0, r_dims} : {27'd0, r_centres};
    assign pready    = 1'b1;
    assign o_centres = r_centres;
    assign o_dims    = r_dims;

endmodule

### hdl/okm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module okm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [okm_pkg::DIV_BITS-1:0]  i_dividend,
    input  logic [okm_pkg::CNT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [okm_pkg::DIV_BITS-1:0]  o_quotient
);
    import okm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W:0]       r_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic [CNT_W-1:0]     r_dvs;
    logic [CNT_W:0]       w_sh;
    logic                 w_ge;

    assign w_sh = {r_rem[CNT_W-1:0], r_quo[DIV_BITS-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hdl/okm_core.sv
// Centre memories, distance pipeline, winner scan and centre update sequencer.
module okm_core #(
    parameter int MAX_CENTRES = 16,
    parameter int MAX_DIMS    = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_centres,
    input  logic [7:0]         i_dims,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  okm_pkg::t_in_item  i_in_data,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output okm_pkg::t_out_item o_res_data
);
    import okm_pkg::*;

    localparam int CW = $clog2(MAX_CENTRES);
    localparam int KW = $clog2(MAX_CENTRES + 1);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW = $clog2(MAX_DIMS + 1);
    localparam int CDEPTH = MAX_CENTRES * (2 ** DW);

    logic [ELEM_W-1:0] m_centre [CDEPTH];
    logic [DIST_W-1:0] m_pd     [MAX_CENTRES];
    logic [CNT_W-1:0]  m_cnt    [MAX_CENTRES];
    logic [ELEM_W-1:0] m_desc   [MAX_DIMS];

    t_state r_state, n_state;
    t_mode  r_mode, w_mode;

    logic [DW-1:0]          r_pos, w_pos, r_epos;
    logic [KW-1:0]          r_slot, r_j, w_k;
    logic [NW-1:0]          w_d, r_n, r_e;
    logic [TOTAL_W-1:0]     r_total;
    logic [MAX_CENTRES-1:0] r_pd_vld;
    logic signed [15:0]     r_x;
    logic                   r_end, w_end, w_fire, w_issue;
    logic                   r_s1_v, r_s2_v;
    logic [CW-1:0]          r_s1_j, r_s2_j, r_win;
    logic [33:0]            r_s2_sq;
    logic [DIST_W-1:0]      r_s2_pd, r_best, w_dist;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    t_out_item              r_res;

    logic [ELEM_W-1:0]   r_cq, r_dq;
    logic [DIST_W-1:0]   r_pdq;
    logic [CNT_W-1:0]    r_cntq;

    logic                c_re, c_we, pd_re, pd_we, cnt_re, cnt_we, d_we, d_re;
    logic [CW+DW-1:0]    c_raddr, c_waddr;
    logic [ELEM_W-1:0]   c_wdata;
    logic [CW-1:0]       pd_raddr, cnt_addr;
    logic [DIST_W-1:0]   pd_wdata;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [DW-1:0]       d_addr;

    logic signed [16:0]  w_diff, w_udiff, w_delta;
    logic signed [33:0]  w_sq;
    logic [39:0]         w_pdsum;
    logic [TOTAL_W:0]    w_tsum;
    logic [16:0]         w_mag, w_quo;
    logic                div_start, div_done;
    logic [16:0]         w_newc;
    logic [CW+3:0]       w_win_ext;
    logic [KW+3:0]       w_slot_ext;

    always_comb begin
        if (i_centres == 5'd0) begin
            w_k = KW'(1);
        end else if (int'(i_centres) > MAX_CENTRES) begin
            w_k = KW'(MAX_CENTRES);
        end else begin
            w_k = KW'(i_centres);
        end
        if (i_dims == 8'd0) begin
            w_d = NW'(1);
        end else if (int'(i_dims) > MAX_DIMS) begin
            w_d = NW'(MAX_DIMS);
        end else begin
            w_d = NW'(i_dims);
        end
        if (int'(r_pos) >= int'(w_d)) begin
            w_pos = DW'(w_d - 1'b1);
        end else begin
            w_pos = r_pos;
        end
        w_end = i_in_data.last_element || (int'(w_pos) + 1 >= int'(w_d));
        if (w_pos == '0) begin
            if (!i_in_data.action) begin
                w_mode = (r_slot < w_k) ? MODE_SEED : MODE_IGNORE;
            end else begin
                w_mode = (r_slot >= w_k) ? MODE_TRAIN : MODE_IGNORE;
            end
        end else begin
            w_mode = r_mode;
        end
    end

    assign w_fire     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_issue    = ((r_state == ST_DIST) || (r_state == ST_SCAN)) && (r_j < w_k);

    assign w_diff  = $signed({r_x[15], r_x}) - $signed({r_cq[15], r_cq});
    assign w_sq    = w_diff * w_diff;
    assign w_pdsum = {1'b0, r_s2_pd} + {6'd0, r_s2_sq};
    assign w_dist  = r_pd_vld[r_s1_j] ? r_pdq : '0;
    assign w_tsum  = {1'b0, r_total} + {{(TOTAL_W + 1 - DIST_W){1'b0}}, w_dist};
    assign w_udiff = $signed({r_dq[15], r_dq}) - $signed({r_cq[15], r_cq});
    assign w_mag   = w_udiff[16] ? 17'(-w_udiff) : 17'(w_udiff);
    assign w_delta = r_neg ? -$signed(w_quo) : $signed(w_quo);
    assign w_newc  = 17'($signed({r_cq[15], r_cq}) + w_delta);
    assign w_win_ext  = (CW + 4)'(r_win);
    assign w_slot_ext = (KW + 4)'(r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        c_re      = 1'b0;
        c_we      = 1'b0;
        c_raddr   = {r_j[CW-1:0], r_epos};
        c_waddr   = {r_slot[CW-1:0], w_pos};
        c_wdata   = i_in_data.element_value;
        pd_re     = 1'b0;
        pd_raddr  = r_j[CW-1:0];
        pd_we     = 1'b0;
        pd_wdata  = w_pdsum[39] ? '1 : w_pdsum[DIST_W-1:0];
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_addr  = r_win;
        cnt_wdata = (r_cntq == '1) ? r_cntq : r_cntq + 1'b1;
        d_we      = 1'b0;
        d_re      = 1'b0;
        d_addr    = w_pos;
        div_start = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    case (w_mode)
                        MODE_SEED: begin
                            c_we = 1'b1;
                            if (w_end) begin
                                cnt_we    = 1'b1;
                                cnt_addr  = r_slot[CW-1:0];
                                cnt_wdata = CNT_W'(1);
                                n_state   = ST_RESULT;
                            end
                        end
                        MODE_TRAIN: begin
                            d_we    = 1'b1;
                            n_state = ST_DIST;
                        end
                        default: begin
                            if (w_end) begin
                                n_state = ST_RESULT;
                            end
                        end
                    endcase
                end
            end
            ST_DIST: begin
                c_re  = w_issue;
                pd_re = w_issue;
                pd_we = r_s2_v;
                if (!w_issue && !r_s1_v && !r_s2_v) begin
                    n_state = r_end ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN: begin
                pd_re = w_issue;
                if (!w_issue && !r_s1_v) begin
                    n_state = ST_CNT_RD;
                end
            end
            ST_CNT_RD: begin
                cnt_re  = 1'b1;
                n_state = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                cnt_we  = 1'b1;
                n_state = ST_UPD_RD;
            end
            ST_UPD_RD: begin
                c_raddr = {r_win, r_e[DW-1:0]};
                d_addr  = r_e[DW-1:0];
                if (r_e < r_n) begin
                    c_re    = 1'b1;
                    d_re    = 1'b1;
                    n_state = ST_UPD_DIV;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_UPD_DIV: begin
                div_start = 1'b1;
                n_state   = ST_UPD_WAIT;
            end
            ST_UPD_WAIT: begin
                c_waddr = {r_win, r_e[DW-1:0]};
                c_wdata = w_newc[15:0];
                if (div_done) begin
                    c_we    = 1'b1;
                    n_state = ST_UPD_RD;
                end
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            m_centre[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_cq <= m_centre[c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pd_we) begin
            m_pd[r_s2_j] <= pd_wdata;
        end
        if (pd_re) begin
            r_pdq <= m_pd[pd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_addr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cntq <= m_cnt[cnt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            m_desc[d_addr] <= i_in_data.element_value;
        end
        if (d_re) begin
            r_dq <= m_desc[d_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SEED;
            r_pos    <= '0;
            r_slot   <= '0;
            r_total  <= '0;
            r_pd_vld <= '0;
            r_j      <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v && (r_state == ST_DIST);
            if (w_issue) begin
                r_j <= r_j + 1'b1;
            end else if (n_state != r_state) begin
                r_j <= '0;
            end
            if (pd_we) begin
                r_pd_vld[r_s2_j] <= 1'b1;
            end
            if (w_fire) begin
                r_mode <= w_mode;
                r_pos  <= w_end ? '0 : w_pos + 1'b1;
                if (w_mode == MODE_TRAIN && w_pos == '0) begin
                    r_pd_vld <= '0;
                end
                if (w_mode == MODE_SEED && w_end) begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (r_state == ST_SCAN && r_s1_v) begin
                r_total <= w_tsum[TOTAL_W] ? '1 : w_tsum[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_j  <= r_j[CW-1:0];
        r_s2_j  <= r_s1_j;
        r_s2_sq <= 34'(w_sq);
        r_s2_pd <= w_dist;
        if (w_fire) begin
            r_x    <= i_in_data.element_value;
            r_epos <= w_pos;
            r_end  <= w_end;
            r_n    <= NW'(w_pos) + 1'b1;
            r_res.centre_index <= (w_mode == MODE_SEED) ? w_slot_ext[3:0] : 4'd0;
            r_res.min_distance <= '0;
            r_res.compactness  <= r_total;
            r_res.status <= (w_mode == MODE_SEED) ? STATUS_SEEDED : STATUS_IGNORED;
        end
        if (r_state == ST_SCAN && r_s1_v) begin
            if (r_s1_j == '0 || w_dist < r_best) begin
                r_best <= w_dist;
                r_win  <= r_s1_j;
            end
        end
        if (r_state == ST_CNT_WR) begin
            r_cnt <= cnt_wdata;
            r_e   <= '0;
        end
        if (r_state == ST_UPD_DIV) begin
            r_neg <= w_udiff[16];
        end
        if (r_state == ST_UPD_WAIT && div_done) begin
            r_e <= r_e + 1'b1;
        end
        if (r_state == ST_UPD_RD && r_e >= r_n) begin
            r_res.centre_index <= w_win_ext[3:0];
            r_res.min_distance <= r_best;
            r_res.compactness  <= r_total;
            r_res.status       <= STATUS_TRAINED;
        end
    end

    okm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (w_quo)
    );

    assign o_res_data = r_res;

endmodule

### hdl/okm_checker.sv
// Port-level checks for the online k-means update block, bound to the top level.
module okm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input okm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input okm_pkg::t_out_item o_out_data
);
    import okm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STATUS_TRAINED
                         || o_out_data.status == STATUS_SEEDED
                         || o_out_data.status == STATUS_IGNORED))
        else $error("undefined status");

    a_seed_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_SEEDED |-> o_out_data.min_distance == '0)
        else $error("seed transfer carries a distance");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_IGNORED
        |-> o_out_data.centre_index == '0 && o_out_data.min_distance == '0)
        else $error("ignored transfer carries centre data");

endmodule

bind online_kmeans_update okm_checker u_okm_checker (.*);
